// ===== sv/krt_pkg.sv =====
`timescale 1ns / 1ps
// krt_pkg: shared types and codes for the keyed record table
// no dependencies; imported by krt_scan and keyed_record_table

package krt_pkg;

  // fixed port field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned KEY_W   = 8;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned DATA_W  = 64;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_STORE  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  // request transaction
  typedef struct packed {
    op_e               op;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
    logic              record_empty;
    logic [DATA_W-1:0] record_data;
  } krt_in_t;

  // response transaction
  typedef struct packed {
    logic              hit;
    logic              dropped;
    logic [SLOT_W-1:0] found_slot;
    logic              out_empty;
    logic [KEY_W-1:0]  out_key;
    logic [DATA_W-1:0] out_data;
  } krt_out_t;

endpackage

// ===== sv/krt_ram.sv =====
`timescale 1ns / 1ps
// krt_ram: generic simple dual-port ram, one write and one read port
// registered read data, available in the cycle after re_i; no dependencies

module krt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== sv/krt_scan.sv =====
`timescale 1ns / 1ps
// krt_scan: slot memory plus the sequencer that scans it per request
// depends on krt_pkg and krt_ram

module krt_scan
  import krt_pkg::*;
#(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned KEY_BITS  = 8,
  parameter int unsigned DATA_BITS = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  krt_in_t  req_i,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output krt_out_t res_o
);

  localparam int unsigned AW     = $clog2(SLOTS);
  localparam int unsigned IW     = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int unsigned WORD_W = 1 + KEY_BITS + DATA_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  // control registers
  state_e           state_q, state_d;
  logic             issue_q, issue_d;
  logic             chk_vld_q, chk_vld_d;
  logic             match_seen_q, match_seen_d;
  logic             empty_seen_q, empty_seen_d;
  logic [SLOTS-1:0] slot_vld_q, slot_vld_d;

  // datapath registers
  op_e                  op_q, op_d;
  logic [KEY_BITS-1:0]  key_q, key_d;
  logic                 emp_q, emp_d;
  logic [DATA_BITS-1:0] data_q, data_d;
  logic [AW-1:0]        rd_idx_q, rd_idx_d;
  logic [AW-1:0]        chk_idx_q, chk_idx_d;
  logic [AW-1:0]        match_idx_q, match_idx_d;
  logic [AW-1:0]        empty_idx_q, empty_idx_d;
  logic                 cap_empty_q, cap_empty_d;
  logic [KEY_BITS-1:0]  cap_key_q, cap_key_d;
  logic [DATA_BITS-1:0] cap_data_q, cap_data_d;

  // memory ports
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // slot returned by the memory, reset value when never written
  logic                 rec_empty;
  logic [KEY_BITS-1:0]  rec_key;
  logic [DATA_BITS-1:0] rec_data;
  logic                 key_hit;

  logic [IW-1:0] slot_ext;
  logic          slot_in_range;
  logic [IW-1:0] match_ext, empty_ext;

  krt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (slot_vld_q[chk_idx_q]) begin
      {rec_empty, rec_key, rec_data} = ram_rdata;
    end else begin
      rec_empty = 1'b1;
      rec_key   = '0;
      rec_data  = '0;
    end
  end

  assign key_hit       = (rec_key == key_q);
  assign slot_ext      = IW'(req_i.slot);
  assign slot_in_range = (32'(req_i.slot) < SLOTS);
  assign req_ready_o   = (state_q == ST_IDLE);

  // sequencer: issue reads, check returning slots, write back
  always_comb begin
    state_d      = state_q;
    issue_d      = issue_q;
    chk_vld_d    = 1'b0;
    match_seen_d = match_seen_q;
    empty_seen_d = empty_seen_q;
    slot_vld_d   = slot_vld_q;
    op_d         = op_q;
    key_d        = key_q;
    emp_d        = emp_q;
    data_d       = data_q;
    rd_idx_d     = rd_idx_q;
    chk_idx_d    = chk_idx_q;
    match_idx_d  = match_idx_q;
    empty_idx_d  = empty_idx_q;
    cap_empty_d  = cap_empty_q;
    cap_key_d    = cap_key_q;
    cap_data_d   = cap_data_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = chk_idx_q;
    ram_wdata    = '0;
    res_valid_o  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          op_d         = req_i.op;
          key_d        = KEY_BITS'(req_i.key);
          emp_d        = req_i.record_empty;
          data_d       = DATA_BITS'(req_i.record_data);
          match_seen_d = 1'b0;
          empty_seen_d = 1'b0;
          if (req_i.op == OP_READ) begin
            rd_idx_d = slot_ext[AW-1:0];
            issue_d  = slot_in_range;
            state_d  = slot_in_range ? ST_SCAN : ST_RESP;
          end else begin
            rd_idx_d = '0;
            issue_d  = 1'b1;
            state_d  = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // read side
        if (issue_q) begin
          ram_re    = 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = rd_idx_q;
          if (op_q == OP_READ || rd_idx_q == AW'(SLOTS - 1)) begin
            issue_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
        // check side
        if (chk_vld_q) begin
          if (op_q == OP_READ || (op_q == OP_LOOKUP && key_hit && !match_seen_q)) begin
            match_seen_d = 1'b1;
            match_idx_d  = chk_idx_q;
            cap_empty_d  = rec_empty;
            cap_key_d    = rec_key;
            cap_data_d   = rec_data;
          end
          if (key_hit && (op_q == OP_STORE || op_q == OP_REMOVE)) begin
            if (!match_seen_q) begin
              match_seen_d = 1'b1;
              match_idx_d  = chk_idx_q;
            end
            ram_we    = 1'b1;
            ram_waddr = chk_idx_q;
            ram_wdata = (op_q == OP_STORE) ? {emp_q, key_q, data_q}
                                           : {1'b1, {(KEY_BITS + DATA_BITS){1'b0}}};
          end
          if (rec_empty && !empty_seen_q) begin
            empty_seen_d = 1'b1;
            empty_idx_d  = chk_idx_q;
          end
          if (!issue_q) begin
            state_d = ST_RESP;
            // no key matched: fill the lowest empty slot
            if (op_q == OP_STORE && !match_seen_d && empty_seen_d) begin
              ram_we    = 1'b1;
              ram_waddr = empty_idx_d;
              ram_wdata = {emp_q, key_q, data_q};
            end
          end
        end
      end

      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (ram_we) begin
      slot_vld_d[ram_waddr] = 1'b1;
    end
  end

  // response formatting
  assign match_ext = IW'(match_idx_q);
  assign empty_ext = IW'(empty_idx_q);

  always_comb begin
    res_o = '{hit: 1'b0, dropped: 1'b0, found_slot: '0, out_empty: 1'b1,
              out_key: '0, out_data: '0};
    unique case (op_q)
      OP_STORE: begin
        if (match_seen_q || empty_seen_q) begin
          res_o.hit        = match_seen_q;
          res_o.found_slot = match_seen_q ? match_ext[SLOT_W-1:0]
                                          : empty_ext[SLOT_W-1:0];
          res_o.out_empty  = emp_q;
          res_o.out_key    = KEY_W'(key_q);
          res_o.out_data   = DATA_W'(data_q);
        end else begin
          res_o.dropped = 1'b1;
        end
      end
      OP_REMOVE: begin
        res_o.hit        = match_seen_q;
        res_o.found_slot = match_seen_q ? match_ext[SLOT_W-1:0] : '0;
      end
      OP_LOOKUP, OP_READ: begin
        if (match_seen_q) begin
          res_o.hit        = 1'b1;
          res_o.found_slot = match_ext[SLOT_W-1:0];
          res_o.out_empty  = cap_empty_q;
          res_o.out_key    = KEY_W'(cap_key_q);
          res_o.out_data   = DATA_W'(cap_data_q);
        end
      end
      default: begin
        res_o.hit = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      issue_q      <= 1'b0;
      chk_vld_q    <= 1'b0;
      match_seen_q <= 1'b0;
      empty_seen_q <= 1'b0;
      slot_vld_q   <= '0;
      op_q         <= OP_STORE;
    end else begin
      state_q      <= state_d;
      issue_q      <= issue_d;
      chk_vld_q    <= chk_vld_d;
      match_seen_q <= match_seen_d;
      empty_seen_q <= empty_seen_d;
      slot_vld_q   <= slot_vld_d;
      op_q         <= op_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    emp_q       <= emp_d;
    data_q      <= data_d;
    rd_idx_q    <= rd_idx_d;
    chk_idx_q   <= chk_idx_d;
    match_idx_q <= match_idx_d;
    empty_idx_q <= empty_idx_d;
    cap_empty_q <= cap_empty_d;
    cap_key_q   <= cap_key_d;
    cap_data_q  <= cap_data_d;
  end

endmodule

// ===== sv/keyed_record_table.sv =====
`timescale 1ns / 1ps
// keyed_record_table: top level, slot scanner and output register
// depends on krt_pkg, krt_scan (which holds krt_ram)
//
//  channel  signals                          direction  payload
//  in       in_valid_i in_ready_o in_data_i  to block   krt_in_t
//  out      out_valid_o out_ready_i out_data_o  from block krt_out_t
//
// store, lookup and remove scan every slot through the single read port of
// the slot memory. read by slot reads only the addressed slot, and skips
// the memory when the slot is out of range.
// reset empties every slot at once through per-slot valid bits; no sweep.
// a finished response waits in the output register, the next request is
// taken while it stalls there.

module keyed_record_table
  import krt_pkg::*;
#(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned KEY_BITS  = 8,
  parameter int unsigned DATA_BITS = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  krt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output krt_out_t out_data_o
);

  logic     res_valid, res_ready;
  krt_out_t res;
  logic     out_valid_q, out_valid_d;
  krt_out_t out_q;

  krt_scan #(
    .SLOTS     (SLOTS),
    .KEY_BITS  (KEY_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_hit_not_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.hit && out_data_o.dropped))
    else $error("response flags both hit and dropped");

  a_dropped_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.dropped) |->
      (out_data_o.found_slot == '0 && out_data_o.out_empty &&
       out_data_o.out_key == '0 && out_data_o.out_data == '0))
    else $error("dropped store returned a non-empty record");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while the previous one is still scanning");

endmodule
